// ===== design/ci_v_frequency_frame_decoder_assert.svh =====
// assertion macros for the ci-v frequency frame decoder
// used by the checker module, no other dependencies
`ifndef CI_V_FREQUENCY_FRAME_DECODER_ASSERT_SVH
`define CI_V_FREQUENCY_FRAME_DECODER_ASSERT_SVH

// property checked on every clock edge outside reset
`define CVFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen outside reset
`define CVFD_NEVER(label, cond, msg) \
   `CVFD_ASSERT(label, !(cond), msg)

`endif

// ===== design/cvfd_pkg.sv =====
// shared constants, types and functions of the ci-v frequency frame decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cvfd_pkg;

   localparam int WINDOW_BYTES = 16;

   localparam int FREQ_WIDTH = 34;
   localparam int DATA_BYTES = 5;

   localparam logic [7:0] END_MARK   = 8'hFD;
   localparam logic [7:0] PREAMBLE   = 8'hFE;
   localparam logic [7:0] CTRL_RESET = 8'hE0;

   // weight of the low nibble, most significant data byte first
   localparam logic [FREQ_WIDTH-1:0] LO_WEIGHT [DATA_BYTES] = '{
      34'd100000000, 34'd1000000, 34'd10000, 34'd100, 34'd1
   };
   // weight of the high nibble, ten times the low one
   localparam logic [FREQ_WIDTH-1:0] HI_WEIGHT [DATA_BYTES] = '{
      34'd1000000000, 34'd10000000, 34'd100000, 34'd1000, 34'd10
   };

   typedef struct packed {
      logic is_preamble;
      logic is_ctrl;
   } cvfd_match_type;

   // nibbles above 9 keep their plain value
   function automatic logic [FREQ_WIDTH-1:0] bcd_byte_value(
      input logic [7:0]            b,
      input logic [FREQ_WIDTH-1:0] w_hi,
      input logic [FREQ_WIDTH-1:0] w_lo
   );
      logic [FREQ_WIDTH-1:0] hi_ext;
      logic [FREQ_WIDTH-1:0] lo_ext;
      hi_ext = {{(FREQ_WIDTH-4){1'b0}}, b[7:4]};
      lo_ext = {{(FREQ_WIDTH-4){1'b0}}, b[3:0]};
      return hi_ext * w_hi + lo_ext * w_lo;
   endfunction

endpackage

`default_nettype wire

// ===== design/ci_v_frequency_frame_decoder.sv =====
// ci-v frequency report decoder: top level with window chain and decode pipeline
// depends on cvfd_pkg and cvfd_cell
//
// usage:
//   req channel: one received serial byte per transaction on req_rx_byte.
//   rsp channel: one transaction per recognized frequency report, carrying the
//     frequency in hertz and short_frame (1 for four data bytes, 0 for five).
//   csr channel: writes the controller address; csr_ready is always high.
//     write it only while no report is in flight.
//   every byte shifts into a chain of byte cells; on the end marker 0xFD the
//   cells ahead of it are matched against preamble, address and layout.
//   throughput: one byte per cycle, sustained, as long as rsp is taken.
//   path: after its end marker is taken, a report passes the weighting stage,
//     then the summing stage into the output register, before it shows on rsp.
//   stall: with rsp held off, one more report waits in the weighting stage;
//     req_ready drops only when both stages are full.
//   reset: window cleared to zero bytes, controller address back to 0xE0,
//     both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module ci_v_frequency_frame_decoder (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_rx_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [cvfd_pkg::FREQ_WIDTH-1:0]        rsp_frequency_hz,
   output logic                                   rsp_short_frame,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [7:0]                        csr_controller_address
);

   localparam int NB = cvfd_pkg::WINDOW_BYTES;
   localparam int DB = cvfd_pkg::DATA_BYTES;
   localparam int FW = cvfd_pkg::FREQ_WIDTH;

   logic [7:0]               ctrl_addr_ff;
   logic [7:0]               ctrl_addr_in;

   logic [7:0]               cell_byte [NB];
   cvfd_pkg::cvfd_match_type cell_match [NB];

   logic                     accept;
   logic                     advance_out;
   logic                     hit_four;
   logic                     hit_five;
   logic                     frame_hit;

   logic [7:0]               aligned [DB];

   logic                     mid_valid_ff;
   logic                     mid_valid_in;
   logic [FW-1:0]            mid_term_ff [DB];
   logic [FW-1:0]            mid_term_in [DB];
   logic                     mid_short_ff;
   logic                     mid_short_in;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [FW-1:0]            rsp_freq_ff;
   logic [FW-1:0]            rsp_freq_in;
   logic                     rsp_short_ff;
   logic                     rsp_short_in;

   // configuration register
   assign csr_ready    = 1'b1;
   assign ctrl_addr_in = (csr_valid && csr_ready) ? csr_controller_address : ctrl_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_addr_ff <= cvfd_pkg::CTRL_RESET;
      end else begin
         ctrl_addr_ff <= ctrl_addr_in;
      end
   end

   // handshake
   assign advance_out = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !mid_valid_ff || advance_out;
   assign accept      = req_valid && req_ready;

   // receive window chain, newest byte enters cell 0
   for (genvar k = 0; k < NB; k++) begin : g_cell
      cvfd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (accept),
         .byte_in   ((k == 0) ? req_rx_byte : cell_byte[(k == 0) ? 0 : k-1]),
         .ctrl_addr (ctrl_addr_ff),
         .byte_out  (cell_byte[k]),
         .match     (cell_match[k])
      );
   end

   // cell k holds what becomes window position k+1 once the end marker enters
   assign hit_four = cell_match[6].is_ctrl && cell_match[7].is_preamble &&
                     cell_match[8].is_preamble;
   assign hit_five = cell_match[7].is_ctrl && cell_match[8].is_preamble &&
                     cell_match[9].is_preamble;
   assign frame_hit = accept && (req_rx_byte == cvfd_pkg::END_MARK) &&
                      (hit_four || hit_five);

   // four-byte reports get a zero top byte so both layouts share the weights
   always_comb begin
      if (hit_four) begin
         aligned[0] = 8'h00;
         for (int i = 1; i < DB; i++) begin
            aligned[i] = cell_byte[i-1];
         end
      end else begin
         for (int i = 0; i < DB; i++) begin
            aligned[i] = cell_byte[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < DB; i++) begin
         mid_term_in[i] = frame_hit ?
            cvfd_pkg::bcd_byte_value(aligned[i], cvfd_pkg::HI_WEIGHT[i],
                                     cvfd_pkg::LO_WEIGHT[i]) :
            mid_term_ff[i];
      end
   end

   assign mid_short_in = frame_hit ? hit_four : mid_short_ff;
   assign mid_valid_in = frame_hit || (mid_valid_ff && !advance_out);

   // summing stage
   assign rsp_valid_in = mid_valid_ff || (rsp_valid_ff && !rsp_ready);
   assign rsp_freq_in  = (mid_valid_ff && advance_out) ?
      ((mid_term_ff[0] + mid_term_ff[1]) + (mid_term_ff[2] + mid_term_ff[3]))
         + mid_term_ff[4] :
      rsp_freq_ff;
   assign rsp_short_in = (mid_valid_ff && advance_out) ? mid_short_ff : rsp_short_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_term_ff  <= mid_term_in;
      mid_short_ff <= mid_short_in;
      rsp_freq_ff  <= rsp_freq_in;
      rsp_short_ff <= rsp_short_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frequency_hz = rsp_freq_ff;
   assign rsp_short_frame  = rsp_short_ff;

endmodule

`default_nettype wire

// ===== design/cvfd_cell.sv =====
// one byte cell of the receive window shift chain
// depends on cvfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module cvfd_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    shift_en,
   input  wire logic [7:0]              byte_in,
   input  wire logic [7:0]              ctrl_addr,
   output logic [7:0]                   byte_out,
   output cvfd_pkg::cvfd_match_type     match
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_mux;

   assign byte_in_mux = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_in_mux;
      end
   end

   assign byte_out          = byte_ff;
   assign match.is_preamble = (byte_ff == cvfd_pkg::PREAMBLE);
   assign match.is_ctrl     = (byte_ff == ctrl_addr);

endmodule

`default_nettype wire

// ===== design/cvfd_checker.sv =====
// port-level checker for the ci-v frequency frame decoder, bound to the top level
// depends on cvfd_pkg and ci_v_frequency_frame_decoder_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "ci_v_frequency_frame_decoder_assert.svh"

module cvfd_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic [7:0]                        req_rx_byte,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [cvfd_pkg::FREQ_WIDTH-1:0]   rsp_frequency_hz,
   input wire logic                              rsp_short_frame,
   input wire logic                              csr_valid,
   input wire logic                              csr_ready
);

   // a stalled result transaction keeps its payload
   `CVFD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frequency_hz) && $stable(rsp_short_frame), "rsp payload changed while stalled")

   // input backpressure only when the output is full and stalled
   `CVFD_ASSERT(a_req_stall, !req_ready |-> rsp_valid && !rsp_ready, "req_ready low without rsp stall")

   // a fresh result follows an accepted end marker, through the weighting and summing registers
   `CVFD_ASSERT(a_rsp_source, $rose(rsp_valid) |-> $past(req_valid && req_ready && req_rx_byte == cvfd_pkg::END_MARK, 2), "result without end marker")

   // configuration writes are never held off
   `CVFD_NEVER(a_csr_ready, csr_valid && !csr_ready, "csr write stalled")

endmodule

bind ci_v_frequency_frame_decoder cvfd_checker u_cvfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_rx_byte      (req_rx_byte),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_frequency_hz (rsp_frequency_hz),
   .rsp_short_frame  (rsp_short_frame),
   .csr_valid        (csr_valid),
   .csr_ready        (csr_ready)
);

`default_nettype wire

// ===== tb/ci_v_frequency_frame_decoder_tb.sv =====
// self-checking testbench for the ci-v frequency frame decoder
// random gaps on byte and result channels, csr writes between phases, predictor checks reports
// depends on cvfd_pkg and the ci_v_frequency_frame_decoder rtl
`timescale 1ns / 1ps

module ci_v_frequency_frame_decoder_tb;

   localparam int CLK_HALF      = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PHASE_BYTES   = 225;

   localparam logic [7:0] CMD_TRANSCEIVE = 8'h00;
   localparam logic [7:0] CMD_READ_FREQ  = 8'h03;
   localparam logic [7:0] ACK_OK         = 8'hFB;

   typedef struct {
      logic [cvfd_pkg::FREQ_WIDTH-1:0] hz;
      logic                            short_frame;
   } freq_report_type;

   typedef logic [7:0] byte_q_type [$];

   class report_scoreboard;
      logic [7:0]      window [cvfd_pkg::WINDOW_BYTES];
      logic [7:0]      dest_addr;
      freq_report_type due [$];
      int              errors;

      function new();
         foreach (window[i]) window[i] = '0;
         dest_addr = cvfd_pkg::CTRL_RESET;
         errors = 0;
      endfunction

      function void set_address(logic [7:0] a);
         dest_addr = a;
      endfunction

      function int pending();
         return due.size();
      endfunction

      // non-decimal nibbles keep their plain value
      function logic [63:0] bcd_worth(logic [7:0] b, logic [63:0] w);
         return 64'(b[7:4]) * w * 64'd10 + 64'(b[3:0]) * w;
      endfunction

      function void note_byte(logic [7:0] b);
         freq_report_type r;
         bit              five_ok;
         bit              four_ok;
         logic [63:0]     sum;
         for (int i = cvfd_pkg::WINDOW_BYTES - 1; i > 0; i--) window[i] = window[i-1];
         window[0] = b;
         if (b != cvfd_pkg::END_MARK) return;
         five_ok = window[8] == dest_addr && window[9] == cvfd_pkg::PREAMBLE &&
                   window[10] == cvfd_pkg::PREAMBLE;
         four_ok = window[7] == dest_addr && window[8] == cvfd_pkg::PREAMBLE &&
                   window[9] == cvfd_pkg::PREAMBLE;
         // the four-byte reading wins when both layouts line up
         if (four_ok) begin
            sum = bcd_worth(window[1], 64'd1000000) + bcd_worth(window[2], 64'd10000)
                + bcd_worth(window[3], 64'd100) + bcd_worth(window[4], 64'd1);
            r.short_frame = 1'b1;
         end else if (five_ok) begin
            sum = bcd_worth(window[1], 64'd100000000) + bcd_worth(window[2], 64'd1000000)
                + bcd_worth(window[3], 64'd10000) + bcd_worth(window[4], 64'd100)
                + bcd_worth(window[5], 64'd1);
            r.short_frame = 1'b0;
         end else begin
            return;
         end
         r.hz = sum[cvfd_pkg::FREQ_WIDTH-1:0];
         due.push_back(r);
      endfunction

      function void check_report(logic [cvfd_pkg::FREQ_WIDTH-1:0] hz, logic short_frame);
         freq_report_type r;
         if (due.size() == 0) begin
            $error("unexpected report: frequency_hz %0d short_frame %0d", hz, short_frame);
            errors++;
            return;
         end
         r = due.pop_front();
         if (hz !== r.hz) begin
            $error("frequency_hz expected %0d actual %0d", r.hz, hz);
            errors++;
         end
         if (short_frame !== r.short_frame) begin
            $error("short_frame expected %0d actual %0d", r.short_frame, short_frame);
            errors++;
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [7:0]                      req_rx_byte = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [cvfd_pkg::FREQ_WIDTH-1:0] rsp_frequency_hz;
   logic                            rsp_short_frame;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [7:0]                      csr_controller_address = '0;

   report_scoreboard sb;
   int unsigned      cycle_count = 0;
   bit               quiet = 1'b0;
   logic [7:0]       cur_addr = cvfd_pkg::CTRL_RESET;

   ci_v_frequency_frame_decoder DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_rx_byte            (req_rx_byte),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_frequency_hz       (rsp_frequency_hz),
      .rsp_short_frame        (rsp_short_frame),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_controller_address (csr_controller_address)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // transaction monitor on all three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_report(rsp_frequency_hz, rsp_short_frame);
         if (req_valid && req_ready) sb.note_byte(req_rx_byte);
         if (csr_valid && csr_ready) sb.set_address(csr_controller_address);
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   task automatic put_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic put_seq(input byte_q_type q);
      foreach (q[i]) put_byte(q[i]);
   endtask

   // only touch the address once every report has drained
   task automatic write_address(input logic [7:0] a);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_controller_address <= a;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_addr = a;
   endtask

   function automatic logic [7:0] data_byte(bit bcd_only);
      if (bcd_only) return {4'($urandom_range(9)), 4'($urandom_range(9))};
      return 8'($urandom_range(255));
   endfunction

   function automatic byte_q_type report_frame(logic [7:0] dest, int n_data, bit bcd_only);
      byte_q_type q;
      logic [7:0] radio;
      logic [7:0] cmd;
      int         r;
      radio = ($urandom_range(3) == 0) ? cvfd_pkg::PREAMBLE : 8'($urandom_range(255));
      r = $urandom_range(2);
      cmd = (r == 0) ? CMD_TRANSCEIVE : (r == 1) ? CMD_READ_FREQ : 8'($urandom_range(255));
      q = {cvfd_pkg::PREAMBLE, cvfd_pkg::PREAMBLE, dest, radio, cmd};
      repeat (n_data) q.push_back(data_byte(bcd_only));
      q.push_back(cvfd_pkg::END_MARK);
      return q;
   endfunction

   task automatic random_traffic(input int n_bytes);
      byte_q_type q;
      int         kind;
      int         pos;
      int         sent;
      sent = 0;
      while (sent < n_bytes) begin
         if ($urandom_range(7) == 0) quiet = !quiet;
         kind = $urandom_range(99);
         if (kind < 60) begin
            q = report_frame(cur_addr, 4 + $urandom_range(1), 1'($urandom_range(1)));
         end else if (kind < 70) begin
            q = report_frame(8'($urandom_range(255)), 4 + $urandom_range(1),
                             1'($urandom_range(1)));
         end else if (kind < 78) begin
            q = {cvfd_pkg::PREAMBLE, cvfd_pkg::PREAMBLE, cur_addr, 8'($urandom_range(255)),
                 ACK_OK, cvfd_pkg::END_MARK};
         end else if (kind < 90) begin
            // corrupted or resized report
            q = report_frame(cur_addr, $urandom_range(3, 6), 1'($urandom_range(1)));
            pos = $urandom_range(q.size() - 2);
            if ($urandom_range(1)) q[pos] = 8'($urandom_range(255));
            else q.delete(pos);
         end else begin
            q = {};
            repeat ($urandom_range(1, 6))
               q.push_back(($urandom_range(3) == 0) ? cvfd_pkg::END_MARK :
                                                      8'($urandom_range(255)));
         end
         put_seq(q);
         sent += q.size();
      end
      quiet = 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-ones nibbles give the largest five-byte sum, zeros the smallest four-byte one
      put_seq({cvfd_pkg::PREAMBLE, cvfd_pkg::PREAMBLE, cvfd_pkg::CTRL_RESET, 8'h00,
               CMD_READ_FREQ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, cvfd_pkg::END_MARK});
      put_seq({cvfd_pkg::PREAMBLE, cvfd_pkg::PREAMBLE, cvfd_pkg::CTRL_RESET, 8'h00,
               CMD_TRANSCEIVE, 8'h00, 8'h00, 8'h00, 8'h00, cvfd_pkg::END_MARK});
      put_seq({cvfd_pkg::END_MARK});
      put_seq({cvfd_pkg::PREAMBLE, cvfd_pkg::PREAMBLE, cvfd_pkg::CTRL_RESET, 8'h00,
               ACK_OK, cvfd_pkg::END_MARK});
      random_traffic(PHASE_BYTES);

      write_address(8'h00);
      random_traffic(PHASE_BYTES);

      write_address(8'hFF);
      random_traffic(PHASE_BYTES);

      // with address FE both layouts can line up at once
      write_address(cvfd_pkg::PREAMBLE);
      put_seq({cvfd_pkg::PREAMBLE, cvfd_pkg::PREAMBLE, cvfd_pkg::PREAMBLE,
               cvfd_pkg::PREAMBLE, cvfd_pkg::PREAMBLE, CMD_READ_FREQ,
               8'h12, 8'h34, 8'h56, 8'h78, cvfd_pkg::END_MARK});
      random_traffic(PHASE_BYTES);

      write_address(8'($urandom_range(255)));
      random_traffic(PHASE_BYTES);

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
